// File: rtl/core/leading_dijet_select_macros.svh
// ----------------------------------------------------------------------------
// leading_dijet_select assertion macros
// Shared concurrent assertion wrappers, empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef LEADING_DIJET_SELECT_MACROS_SVH
`define LEADING_DIJET_SELECT_MACROS_SVH

`ifndef SYNTHESIS
`define LDJ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("leading_dijet_select: same-cycle check failed");
`define LDJ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("leading_dijet_select: next-cycle check failed");
`else
`define LDJ_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define LDJ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/core/ldj_pkg.sv
// ----------------------------------------------------------------------------
// ldj_pkg
// Types, constants and helpers for the leading dijet selector.
// ----------------------------------------------------------------------------
package ldj_pkg;

    localparam int MAX_JETS     = 64;
    localparam int AZIMUTH_BITS = 10;

    localparam int PT_W        = 16;
    localparam int ETA_W       = 10;
    localparam int PHI_W       = 10;
    localparam int ETA_LIM_W   = 9;
    localparam int GAP_W       = 10;
    localparam int IDX_W       = 6;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 16;

    localparam int CNT_W       = $clog2(MAX_JETS + 1);
    localparam int POS_W       = $clog2(MAX_JETS);
    localparam int CMP_W       = (AZIMUTH_BITS > GAP_W) ? AZIMUTH_BITS : GAP_W;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [AZIMUTH_BITS-1:0] AZ_HALF = AZIMUTH_BITS'(1) << (AZIMUTH_BITS - 1);

    localparam logic [ETA_LIM_W-1:0] ETA_LIMIT_RST      = ETA_LIM_W'(200);
    localparam logic [PT_W-1:0]      LEAD_PT_MIN_RST    = PT_W'(400);
    localparam logic [PT_W-1:0]      SUBLEAD_PT_MIN_RST = PT_W'(160);
    localparam logic [GAP_W-1:0]     GAP_MIN_RST        = GAP_W'(341);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ETA_LIMIT      = 8'd0,
        CFG_LEAD_PT_MIN    = 8'd1,
        CFG_SUBLEAD_PT_MIN = 8'd2,
        CFG_GAP_MIN        = 8'd3
    } t_cfg_reg;

    typedef struct packed {
        logic                    keep;
        logic [PT_W-1:0]         pt;
        logic [POS_W-1:0]        pos;
        logic [AZIMUTH_BITS-1:0] az;
        logic                    last;
        logic                    ovf;
    } t_item;

    typedef struct packed {
        logic                    vld;
        logic [PT_W-1:0]         pt;
        logic [POS_W-1:0]        pos;
        logic [AZIMUTH_BITS-1:0] az;
    } t_cand;

    typedef struct packed {
        t_cand first;
        t_cand second;
        logic  ovf;
    } t_snap;

    function automatic logic [AZIMUTH_BITS-1:0] folded_gap(
        input logic [AZIMUTH_BITS-1:0] a,
        input logic [AZIMUTH_BITS-1:0] b
    );
        logic [AZIMUTH_BITS-1:0] d;
        d = a - b;
        return (d > AZ_HALF) ? (~d + AZIMUTH_BITS'(1)) : d;
    endfunction

endpackage

// File: rtl/core/ldj_front.sv
// ----------------------------------------------------------------------------
// ldj_front
// Accepts jets, applies the eta cut, numbers positions and tracks overflow.
// ----------------------------------------------------------------------------
module ldj_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_jet_valid,
    input  logic [ldj_pkg::PT_W-1:0]            i_jet_pt,
    input  logic signed [ldj_pkg::ETA_W-1:0]    i_jet_eta,
    input  logic [ldj_pkg::PHI_W-1:0]           i_jet_phi,
    input  logic                                i_last_jet,
    input  logic [ldj_pkg::ETA_LIM_W-1:0]       i_eta_limit,
    output logic                                o_push_valid,
    input  logic                                i_push_ready,
    output ldj_pkg::t_item                      o_push_item
);

    logic [ldj_pkg::CNT_W-1:0] r_pos, n_pos;
    logic                      r_ovf, n_ovf;
    logic                      accept;
    logic                      full;
    logic                      in_cut;
    logic [ldj_pkg::ETA_W-1:0] eta_u;
    logic [ldj_pkg::ETA_W-1:0] mag;

    assign o_in_ready   = i_push_ready;
    assign o_push_valid = i_in_valid;
    assign accept       = i_in_valid & i_push_ready;

    assign eta_u  = $unsigned(i_jet_eta);
    assign mag    = eta_u[ldj_pkg::ETA_W-1] ? (~eta_u + ldj_pkg::ETA_W'(1)) : eta_u;
    assign in_cut = mag <= ldj_pkg::ETA_W'(i_eta_limit);
    assign full   = r_pos == ldj_pkg::CNT_W'(ldj_pkg::MAX_JETS);

    always_comb begin
        o_push_item.keep = i_jet_valid & ~full & in_cut;
        o_push_item.pt   = i_jet_pt;
        o_push_item.pos  = ldj_pkg::POS_W'(r_pos);
        o_push_item.az   = ldj_pkg::AZIMUTH_BITS'(i_jet_phi);
        o_push_item.last = i_last_jet;
        o_push_item.ovf  = r_ovf | (i_jet_valid & full);
    end

    always_comb begin
        n_pos = r_pos;
        n_ovf = r_ovf;
        if (accept) begin
            if (i_last_jet) begin
                n_pos = '0;
                n_ovf = 1'b0;
            end else if (i_jet_valid) begin
                if (full) begin
                    n_ovf = 1'b1;
                end else begin
                    n_pos = r_pos + ldj_pkg::CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_ovf <= 1'b0;
        end else begin
            r_pos <= n_pos;
            r_ovf <= n_ovf;
        end
    end

endmodule

// File: rtl/core/ldj_queue.sv
// ----------------------------------------------------------------------------
// ldj_queue
// Short FIFO of classified jets between the front and back sections.
// ----------------------------------------------------------------------------
module ldj_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  ldj_pkg::t_item i_push_item,
    output logic           o_pop_valid,
    input  logic           i_pop_ready,
    output ldj_pkg::t_item o_pop_item
);

    ldj_pkg::t_item             r_mem [ldj_pkg::QUEUE_DEPTH];
    logic [ldj_pkg::QPTR_W-1:0] r_wr;
    logic [ldj_pkg::QPTR_W-1:0] r_rd;
    logic [ldj_pkg::QCNT_W-1:0] r_count;
    logic                       push;
    logic                       pop;

    assign o_push_ready = r_count != ldj_pkg::QCNT_W'(ldj_pkg::QUEUE_DEPTH);
    assign o_pop_valid  = r_count != '0;
    assign o_pop_item   = r_mem[r_rd];
    assign push         = i_push_valid & o_push_ready;
    assign pop          = o_pop_valid & i_pop_ready;

    function automatic logic [ldj_pkg::QPTR_W-1:0] ptr_inc(
        input logic [ldj_pkg::QPTR_W-1:0] p
    );
        return (p == ldj_pkg::QPTR_W'(ldj_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                 : p + ldj_pkg::QPTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= ptr_inc(r_wr);
            end
            if (pop) begin
                r_rd <= ptr_inc(r_rd);
            end
            unique case ({push, pop})
                2'b10:   r_count <= r_count + ldj_pkg::QCNT_W'(1);
                2'b01:   r_count <= r_count - ldj_pkg::QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: rtl/core/ldj_back.sv
// ----------------------------------------------------------------------------
// ldj_back
// Keeps the two highest-pt jets, snapshots them at event end, forms flags.
// ----------------------------------------------------------------------------
module ldj_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_pop_valid,
    output logic                        o_pop_ready,
    input  ldj_pkg::t_item              i_pop_item,
    input  logic [ldj_pkg::PT_W-1:0]    i_lead_pt_min,
    input  logic [ldj_pkg::PT_W-1:0]    i_sublead_pt_min,
    input  logic [ldj_pkg::GAP_W-1:0]   i_gap_min,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_lead_found,
    output logic [ldj_pkg::IDX_W-1:0]   o_lead_index,
    output logic                        o_sublead_found,
    output logic [ldj_pkg::IDX_W-1:0]   o_sublead_index,
    output logic                        o_has_leading,
    output logic                        o_has_dijet,
    output logic                        o_overflow
);

    ldj_pkg::t_cand r_first, n_first;
    ldj_pkg::t_cand r_second, n_second;
    ldj_pkg::t_cand cand;
    ldj_pkg::t_snap r_snap;
    logic           r_snap_vld;
    logic           r_out_vld;
    logic           snap_move;
    logic           snap_free;
    logic           pop;

    logic                                has_lead;
    logic                                has_dijet;
    logic [ldj_pkg::AZIMUTH_BITS-1:0]    gap;

    logic                        r_lead_found;
    logic [ldj_pkg::IDX_W-1:0]   r_lead_index;
    logic                        r_sublead_found;
    logic [ldj_pkg::IDX_W-1:0]   r_sublead_index;
    logic                        r_has_leading;
    logic                        r_has_dijet;
    logic                        r_overflow;

    assign snap_move   = r_snap_vld & (~r_out_vld | i_out_ready);
    assign snap_free   = ~r_snap_vld | snap_move;
    assign o_pop_ready = ~i_pop_item.last | snap_free;
    assign pop         = i_pop_valid & o_pop_ready;

    always_comb begin
        cand.vld = 1'b1;
        cand.pt  = i_pop_item.pt;
        cand.pos = i_pop_item.pos;
        cand.az  = i_pop_item.az;
        n_first  = r_first;
        n_second = r_second;
        if (i_pop_item.keep) begin
            // ties stay with the earlier jet
            if (!r_first.vld || i_pop_item.pt > r_first.pt) begin
                n_second = r_first;
                n_first  = cand;
            end else if (!r_second.vld || i_pop_item.pt > r_second.pt) begin
                n_second = cand;
            end
        end
    end

    assign gap      = ldj_pkg::folded_gap(r_snap.first.az, r_snap.second.az);
    assign has_lead = r_snap.first.vld & (r_snap.first.pt > i_lead_pt_min);
    assign has_dijet = has_lead & r_snap.second.vld
                     & (r_snap.second.pt > i_sublead_pt_min)
                     & (ldj_pkg::CMP_W'(gap) > ldj_pkg::CMP_W'(i_gap_min));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first    <= '0;
            r_second   <= '0;
            r_snap_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (pop) begin
                if (i_pop_item.last) begin
                    r_first  <= '0;
                    r_second <= '0;
                end else begin
                    r_first  <= n_first;
                    r_second <= n_second;
                end
            end
            r_snap_vld <= (pop & i_pop_item.last) | (r_snap_vld & ~snap_move);
            r_out_vld  <= snap_move | (r_out_vld & ~i_out_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && i_pop_item.last) begin
            r_snap.first  <= n_first;
            r_snap.second <= n_second;
            r_snap.ovf    <= i_pop_item.ovf;
        end
        if (snap_move) begin
            r_lead_found    <= r_snap.first.vld;
            r_lead_index    <= r_snap.first.vld ? ldj_pkg::IDX_W'(r_snap.first.pos) : '0;
            r_sublead_found <= r_snap.second.vld;
            r_sublead_index <= r_snap.second.vld ? ldj_pkg::IDX_W'(r_snap.second.pos) : '0;
            r_has_leading   <= has_lead;
            r_has_dijet     <= has_dijet;
            r_overflow      <= r_snap.ovf;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_lead_found    = r_lead_found;
    assign o_lead_index    = r_lead_index;
    assign o_sublead_found = r_sublead_found;
    assign o_sublead_index = r_sublead_index;
    assign o_has_leading   = r_has_leading;
    assign o_has_dijet     = r_has_dijet;
    assign o_overflow      = r_overflow;

endmodule

// File: rtl/core/leading_dijet_select.sv
// ----------------------------------------------------------------------------
// leading_dijet_select
// Throughput: one item per cycle unless the queue is full, or a last item
// finds the snapshot register still holding the previous event's result.
// Results sit in an output register, so input is taken while a result waits.
// Reset: synchronous active low; clears event state, queue, result valid and
// restores configuration registers to their default values.
// ----------------------------------------------------------------------------
`include "leading_dijet_select_macros.svh"

module leading_dijet_select (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_ready,
    input  logic                                    i_jet_valid,
    input  logic [ldj_pkg::PT_W-1:0]                i_jet_pt,
    input  logic signed [ldj_pkg::ETA_W-1:0]        i_jet_eta,
    input  logic [ldj_pkg::PHI_W-1:0]               i_jet_phi,
    input  logic                                    i_last_jet,
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output logic                                    o_lead_found,
    output logic [ldj_pkg::IDX_W-1:0]               o_lead_index,
    output logic                                    o_sublead_found,
    output logic [ldj_pkg::IDX_W-1:0]               o_sublead_index,
    output logic                                    o_has_leading,
    output logic                                    o_has_dijet,
    output logic                                    o_overflow,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [ldj_pkg::CFG_IDX_W-1:0]           i_cfg_index,
    input  logic [ldj_pkg::CFG_DATA_W-1:0]          i_cfg_data
);

    logic [ldj_pkg::ETA_LIM_W-1:0] r_eta_limit;
    logic [ldj_pkg::PT_W-1:0]      r_lead_pt_min;
    logic [ldj_pkg::PT_W-1:0]      r_sublead_pt_min;
    logic [ldj_pkg::GAP_W-1:0]     r_gap_min;
    logic                          cfg_wr;

    logic           push_valid;
    logic           push_ready;
    ldj_pkg::t_item push_item;
    logic           pop_valid;
    logic           pop_ready;
    ldj_pkg::t_item pop_item;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid & o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eta_limit      <= ldj_pkg::ETA_LIMIT_RST;
            r_lead_pt_min    <= ldj_pkg::LEAD_PT_MIN_RST;
            r_sublead_pt_min <= ldj_pkg::SUBLEAD_PT_MIN_RST;
            r_gap_min        <= ldj_pkg::GAP_MIN_RST;
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                ldj_pkg::CFG_ETA_LIMIT: begin
                    r_eta_limit <= i_cfg_data[ldj_pkg::ETA_LIM_W-1:0];
                end
                ldj_pkg::CFG_LEAD_PT_MIN: begin
                    r_lead_pt_min <= i_cfg_data[ldj_pkg::PT_W-1:0];
                end
                ldj_pkg::CFG_SUBLEAD_PT_MIN: begin
                    r_sublead_pt_min <= i_cfg_data[ldj_pkg::PT_W-1:0];
                end
                ldj_pkg::CFG_GAP_MIN: begin
                    r_gap_min <= i_cfg_data[ldj_pkg::GAP_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    ldj_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_jet_valid  (i_jet_valid),
        .i_jet_pt     (i_jet_pt),
        .i_jet_eta    (i_jet_eta),
        .i_jet_phi    (i_jet_phi),
        .i_last_jet   (i_last_jet),
        .i_eta_limit  (r_eta_limit),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_item  (push_item)
    );

    ldj_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_item  (push_item),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_item   (pop_item)
    );

    ldj_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_pop_valid      (pop_valid),
        .o_pop_ready      (pop_ready),
        .i_pop_item       (pop_item),
        .i_lead_pt_min    (r_lead_pt_min),
        .i_sublead_pt_min (r_sublead_pt_min),
        .i_gap_min        (r_gap_min),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_lead_found     (o_lead_found),
        .o_lead_index     (o_lead_index),
        .o_sublead_found  (o_sublead_found),
        .o_sublead_index  (o_sublead_index),
        .o_has_leading    (o_has_leading),
        .o_has_dijet      (o_has_dijet),
        .o_overflow       (o_overflow)
    );

    `LDJ_ASSERT_IMPL(a_sub_needs_lead, i_clk, i_rst_n,
        o_out_valid && o_sublead_found, o_lead_found)
    `LDJ_ASSERT_IMPL(a_dijet_needs_pair, i_clk, i_rst_n,
        o_out_valid && o_has_dijet, o_has_leading && o_sublead_found)
    `LDJ_ASSERT_IMPL(a_no_lead_zero, i_clk, i_rst_n,
        o_out_valid && !o_lead_found, o_lead_index == '0 && !o_has_leading)
    `LDJ_ASSERT_NEXT(a_gap_cfg_write, i_clk, i_rst_n,
        cfg_wr && i_cfg_index == ldj_pkg::CFG_GAP_MIN,
        r_gap_min == $past(i_cfg_data[ldj_pkg::GAP_W-1:0]))

endmodule
